>>> rtl/etd_pkg.sv
// shared types for the euler totient trial division block
`timescale 1ns / 1ps

package etd_pkg;

   // handshake status of the shared divider
   typedef struct packed {
      logic busy;
      logic done;
   } etd_div_status_type;

endpackage

>>> rtl/etd_divider.sv
// restoring divider, one quotient bit per cycle, shared by the totient sequencer
`timescale 1ns / 1ps

module etd_divider
   import etd_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DATA_WIDTH-1:0] dividend,
   input  logic [DATA_WIDTH-1:0] divisor,
   output logic [DATA_WIDTH-1:0] quotient,
   output logic [DATA_WIDTH-1:0] remainder,
   output etd_div_status_type    status
);

   localparam int CNT_W = $clog2(DATA_WIDTH);

   logic [DATA_WIDTH-1:0] quo_ff, quo_in;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] dvs_ff;
   logic [CNT_W-1:0]      count_ff;
   logic                  busy_ff;
   logic                  done_ff;
   logic [DATA_WIDTH:0]   trial;
   logic [DATA_WIDTH:0]   diff;

   always_comb begin
      trial = {rem_ff, quo_ff[DATA_WIDTH-1]};
      diff  = trial - {1'b0, dvs_ff};
      if (!diff[DATA_WIDTH]) begin
         rem_in = diff[DATA_WIDTH-1:0];
         quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b1};
      end else begin
         rem_in = trial[DATA_WIDTH-1:0];
         quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
         end else if (busy_ff) begin
            count_ff <= count_ff + 1'b1;
            if (count_ff == CNT_W'(DATA_WIDTH - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign quotient    = quo_ff;
   assign remainder   = rem_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("divider done while still busy");
   assert property (@(posedge clock) disable iff (reset) start |=> busy_ff)
      else $error("divider did not start");
   assert property (@(posedge clock) disable iff (reset) busy_ff |-> !start)
      else $error("divider restarted while busy");

endmodule

>>> rtl/euler_totient_trial_division_core.sv
// Euler totient by trial division: takes n, returns phi(n), one item at a time.
// Each division on the shared restoring divider is a launch, one quotient bit
// per cycle, and completion. Every candidate divisor needs one division for the
// bound and divisibility test. A prime that divides n k times adds k + 1 more:
// k - 1 further strips, the strip that fails, and the result update. A prime
// cofactor left at the end adds one. The result is offered once these divisions
// are done. The worst case is a prime near 2^DATA_WIDTH, about 2^(DATA_WIDTH/2)
// candidates. req_stall is high from acceptance until the result has been taken;
// inputs 0 and 1 return themselves.
`timescale 1ns / 1ps

module euler_totient_trial_division_core
   import etd_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [DATA_WIDTH-1:0] req_number,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [DATA_WIDTH-1:0] rsp_totient
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_TEST,
      S_STRIP,
      S_REDUCE,
      S_TAIL,
      S_DONE
   } state_type;

   state_type             state_ff;
   logic [DATA_WIDTH-1:0] acc_ff;
   logic [DATA_WIDTH-1:0] rest_ff;
   logic [DATA_WIDTH-1:0] cand_ff;
   logic                  start_ff;

   logic [DATA_WIDTH-1:0] div_dividend;
   logic [DATA_WIDTH-1:0] div_divisor;
   logic [DATA_WIDTH-1:0] div_quo;
   logic [DATA_WIDTH-1:0] div_rem;
   etd_div_status_type    div_status;

   // result updates divide the running result, the rest divide the cofactor
   always_comb begin
      div_dividend = (state_ff == S_REDUCE || state_ff == S_TAIL) ? acc_ff : rest_ff;
      div_divisor  = (state_ff == S_TAIL) ? rest_ff : cand_ff;
   end

   etd_divider #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (start_ff),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .quotient  (div_quo),
      .remainder (div_rem),
      .status    (div_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         start_ff <= 1'b0;
      end else begin
         start_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  acc_ff   <= req_number;
                  rest_ff  <= req_number;
                  cand_ff  <= DATA_WIDTH'(2);
                  start_ff <= 1'b1;
                  state_ff <= S_TEST;
               end
            end
            S_TEST: begin
               if (div_status.done) begin
                  if (cand_ff > div_quo) begin
                     // cand squared exceeds cofactor: leftover is prime or one
                     if (rest_ff > DATA_WIDTH'(1)) begin
                        start_ff <= 1'b1;
                        state_ff <= S_TAIL;
                     end else begin
                        state_ff <= S_DONE;
                     end
                  end else if (div_rem == '0) begin
                     rest_ff  <= div_quo;
                     start_ff <= 1'b1;
                     state_ff <= S_STRIP;
                  end else begin
                     cand_ff  <= cand_ff + 1'b1;
                     start_ff <= 1'b1;
                  end
               end
            end
            S_STRIP: begin
               if (div_status.done) begin
                  if (div_rem == '0) begin
                     rest_ff <= div_quo;
                  end else begin
                     state_ff <= S_REDUCE;
                  end
                  start_ff <= 1'b1;
               end
            end
            S_REDUCE: begin
               if (div_status.done) begin
                  acc_ff   <= acc_ff - div_quo;
                  cand_ff  <= cand_ff + 1'b1;
                  start_ff <= 1'b1;
                  state_ff <= S_TEST;
               end
            end
            S_TAIL: begin
               if (div_status.done) begin
                  acc_ff   <= acc_ff - div_quo;
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (!rsp_stall) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = (state_ff == S_DONE);
   assign rsp_totient = acc_ff;

   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> req_stall)
      else $error("input taken while a result is pending");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TAIL) |-> (rest_ff > DATA_WIDTH'(1)))
      else $error("final update with cofactor not above one");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STRIP || state_ff == S_REDUCE) |-> (rest_ff != '0))
      else $error("zero cofactor while stripping a factor");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TEST || state_ff == S_STRIP || state_ff == S_REDUCE)
         |-> (cand_ff >= DATA_WIDTH'(2)))
      else $error("candidate divisor below two");
   assert property (@(posedge clock) disable iff (reset)
      start_ff |-> (div_divisor != '0))
      else $error("division launched with zero divisor");
   assert property (@(posedge clock) disable iff (reset)
      start_ff |-> !div_status.busy)
      else $error("division launched while the divider is busy");

endmodule
